[design/pid_pkg.sv]
package pid_pkg;

    // Item field widths
    localparam int OPC_W    = 2;
    localparam int ID_W     = 7;
    localparam int HANDLE_W = 16;
    localparam int STAT_W   = 2;

    // Opcodes
    localparam logic [OPC_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OPC_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OPC_W-1:0] OP_FREE   = 2'd2;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic clear_wr;  // write one entry of the reset sweep
        logic capture;   // latch the accepted item, read the free-list head
        logic look;      // read the owner table
        logic exec;      // update tables and pointers, load the result
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clear_last;  // sweep is at its last entry
    } stat_t;

endpackage

[design/pid_ctrl.sv]
module pid_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  pid_pkg::stat_t stat,
    output pid_pkg::cmd_t  cmd
);
    import pid_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_LOOK  = 2'd2;
    localparam logic [1:0] S_EXEC  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       exec_fire;

    // Retire only when the result register is free or being drained.
    assign exec_fire = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.clear_wr = (state_reg == S_CLEAR);
        cmd.capture  = (state_reg == S_IDLE) && in_valid;
        cmd.look     = (state_reg == S_LOOK);
        cmd.exec     = exec_fire;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (exec_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[design/pid_datapath.sv]
module pid_datapath #(
    parameter int NUM_IDS     = 128,
    parameter int HANDLE_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  pid_pkg::cmd_t                     cmd,
    output pid_pkg::stat_t                    stat,
    input  logic [pid_pkg::OPC_W-1:0]         opcode,
    input  logic [pid_pkg::ID_W-1:0]          id_in,
    input  logic [pid_pkg::HANDLE_W-1:0]      handle_in,
    output logic [pid_pkg::ID_W-1:0]          id_out,
    output logic [pid_pkg::HANDLE_W-1:0]      handle_out,
    output logic [pid_pkg::STAT_W-1:0]        status
);
    import pid_pkg::*;

    localparam int IDX_W = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
    localparam int CNT_W = $clog2(NUM_IDS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_IDS - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(NUM_IDS);

    // Free-list ring and owner table
    logic [IDX_W-1:0]       free_ids [NUM_IDS];
    logic [HANDLE_BITS-1:0] owner_table [NUM_IDS];

    // Control state
    logic [IDX_W-1:0] clr_cnt_reg;
    logic [IDX_W-1:0] clr_cnt_next;
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [IDX_W-1:0] tail_reg;
    logic [IDX_W-1:0] tail_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Captured item and read data
    logic [OPC_W-1:0]       op_reg;
    logic [ID_W-1:0]        id_reg;
    logic [HANDLE_BITS-1:0] hdl_reg;
    logic [IDX_W-1:0]       fid_q_reg;
    logic [HANDLE_BITS-1:0] own_q_reg;

    // Result registers
    logic [ID_W-1:0]     out_id_reg;
    logic [HANDLE_W-1:0] out_hdl_reg;
    logic [STAT_W-1:0]   out_st_reg;

    logic [IDX_W-1:0]       id_idx;
    logic                   id_ok;
    logic                   list_empty;
    logic                   list_full;
    logic [IDX_W-1:0]       own_rd_addr;

    logic                   own_we;
    logic [IDX_W-1:0]       own_wa;
    logic [HANDLE_BITS-1:0] own_wd;
    logic                   fid_we;
    logic [IDX_W-1:0]       fid_wa;
    logic [IDX_W-1:0]       fid_wd;

    logic [ID_W-1:0]        res_id;
    logic [HANDLE_BITS-1:0] res_hdl;
    logic [STAT_W-1:0]      res_st;

    assign id_idx      = IDX_W'({{IDX_W{1'b0}}, id_reg});
    assign id_ok       = ({25'd0, id_reg} < 32'(NUM_IDS));
    assign list_empty  = (count_reg == '0);
    assign list_full   = (count_reg == FULL_CNT);
    assign own_rd_addr = (op_reg == OP_ALLOC) ? fid_q_reg : id_idx;

    assign stat.clear_last = (clr_cnt_reg == LAST_IDX);
    assign clr_cnt_next    = stat.clear_last ? '0 : clr_cnt_reg + 1'b1;

    // Work out the update and the result of the current item.
    always_comb
    begin
        own_we     = 1'b0;
        own_wa     = clr_cnt_reg;
        own_wd     = '0;
        fid_we     = 1'b0;
        fid_wa     = clr_cnt_reg;
        fid_wd     = clr_cnt_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        res_id     = id_reg;
        res_hdl    = '0;
        res_st     = ST_OK;

        if (cmd.clear_wr)
        begin
            own_we = 1'b1;
            fid_we = 1'b1;
        end
        else if (cmd.exec)
        begin
            case (op_reg)
                OP_ALLOC:
                begin
                    if (list_empty)
                    begin
                        res_id = '0;
                        res_st = ST_EMPTY;
                    end
                    else
                    begin
                        head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
                        count_next = count_reg - 1'b1;
                        res_id     = ID_W'({{ID_W{1'b0}}, fid_q_reg});
                        res_hdl    = own_q_reg;
                        own_we     = 1'b1;
                        own_wa     = fid_q_reg;
                        own_wd     = hdl_reg;
                    end
                end
                OP_LOOKUP:
                begin
                    if (id_ok)
                    begin
                        res_hdl = own_q_reg;
                    end
                end
                OP_FREE:
                begin
                    if (id_ok)
                    begin
                        res_hdl = own_q_reg;
                        own_we  = 1'b1;
                        own_wa  = id_idx;
                        own_wd  = '0;
                        if (list_full)
                        begin
                            res_st = ST_FULL;
                        end
                        else
                        begin
                            fid_we     = 1'b1;
                            fid_wa     = tail_reg;
                            fid_wd     = id_idx;
                            tail_next  = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    res_id = id_reg;
                end
            endcase
        end
    end

    // Memories: one write port each, registered reads.
    always_ff @(posedge clk)
    begin
        if (fid_we)
        begin
            free_ids[fid_wa] <= fid_wd;
        end
        if (cmd.capture)
        begin
            fid_q_reg <= free_ids[head_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (own_we)
        begin
            owner_table[own_wa] <= own_wd;
        end
        if (cmd.look)
        begin
            own_q_reg <= owner_table[own_rd_addr];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= opcode;
            id_reg  <= id_in;
            hdl_reg <= HANDLE_BITS'({{HANDLE_BITS{1'b0}}, handle_in});
        end
        if (cmd.exec)
        begin
            out_id_reg  <= res_id;
            out_hdl_reg <= HANDLE_W'({{HANDLE_W{1'b0}}, res_hdl});
            out_st_reg  <= res_st;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= FULL_CNT;
        end
        else
        begin
            if (cmd.clear_wr)
            begin
                clr_cnt_reg <= clr_cnt_next;
            end
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    assign id_out     = out_id_reg;
    assign handle_out = out_hdl_reg;
    assign status     = out_st_reg;

endmodule

[design/process_id_allocator.sv]
// Identifier allocator: a ring-buffer free list of identifiers plus an owner
// table holding the handle bound to each identifier. Each input item carries
// an opcode in tuser (allocate, look up, free) and produces exactly one
// result item whose tuser holds the status (ok, no free identifier, free list
// already full). After reset the block sweeps both memories, writing
// identifier i into free-list entry i and clearing owner entry i, while
// s_axis_tready stays low. After that, each item passes through accept plus
// free-list head read, owner-table read (its address depends on the
// free-list read for allocate), then the table and pointer update with the
// result loaded into the output register. The two dependent registered
// memory reads set this sequence. The output register lets the next item be
// accepted while a result waits; a new result is retired only once the
// output register is free or draining.
module process_id_allocator #(
    parameter int NUM_IDS     = 128,
    parameter int HANDLE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    // Input item stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [6:0] id_in, [22:7] handle_in, [23] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    // Result item stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [6:0] id_out, [22:7] handle_out, [23] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import pid_pkg::*;

    cmd_t                cmd;
    stat_t               stat;
    logic [ID_W-1:0]     id_out;
    logic [HANDLE_W-1:0] handle_out;
    logic [STAT_W-1:0]   status;

    // Sequence the clearing sweep and each item's read, read, update steps.
    pid_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Hold the memories, ring pointers, fill count and result register.
    pid_datapath #(
        .NUM_IDS     (NUM_IDS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .opcode     (s_axis_tuser),
        .id_in      (s_axis_tdata[6:0]),
        .handle_in  (s_axis_tdata[22:7]),
        .id_out     (id_out),
        .handle_out (handle_out),
        .status     (status)
    );

    assign m_axis_tdata = {1'b0, handle_out, id_out};
    assign m_axis_tuser = status;

endmodule
